// File: sv/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define DLTQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Overlapping implication checked at every clock edge outside reset.
`define DLTQ_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked at every clock edge outside reset.
`define DLTQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/dltq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dltq_pkg;

  // Number of timer slots in the list.
  localparam int DEPTH    = 16;
  // Most tags reported by one tick.
  localparam int MAX_FIRE = 16;

  localparam int DELTA_W = 16;
  localparam int TAG_W   = 8;
  localparam int SLOT_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int FIRE_W  = $clog2(MAX_FIRE + 1);

  // Input action codes.
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_ADD  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // capture the accepted input beat
    logic walk_step;    // pass one slot during an add
    logic insert;       // insert the new entry and post its result
    logic reject;       // post the result for an add to a full list
    logic idle_result;  // post a result that reports no expiry
    logic dec_head;     // decrement the head delta, clamped at zero
    logic pop;          // remove the head entry and post it as fired
  } dltq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic walk_done;
    logic can_fire;
    logic fire_last;
  } dltq_status_t;

endpackage

`default_nettype wire

// File: sv/dltq_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one beat is one tick or one add request.
interface dltq_in_if import dltq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               action;
  logic [DELTA_W-1:0] delay;
  logic [TAG_W-1:0]   event_tag;

  modport source (output valid, action, delay, event_tag, input ready);
  modport sink   (input valid, action, delay, event_tag, output ready);
endinterface

`default_nettype wire

// File: sv/dltq_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Result channel: one beat per reported result.
interface dltq_out_if import dltq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             fired;
  logic [TAG_W-1:0] expired_tag;
  logic [CNT_W-1:0] entry_total;
  logic             rejected;
  logic             last;

  modport source (output valid, fired, expired_tag, entry_total, rejected, last,
                  input ready);
  modport sink   (input valid, fired, expired_tag, entry_total, rejected, last,
                  output ready);
endinterface

`default_nettype wire

// File: sv/dltq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dltq_ctrl import dltq_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  input  wire logic         in_action_i,
  output logic              in_ready_o,
  input  wire logic         out_ready_i,
  output logic              out_valid_o,
  input  wire dltq_status_t st_i,
  output dltq_cmd_t         cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_WALK   = 5'b00010,
    S_INSERT = 5'b00100,
    S_TICK   = 5'b01000,
    S_CHECK  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   produce;

  // The result register can take a new beat when empty or being drained.
  assign out_free = !out_valid_q || out_ready_i;

  // Sequencer for add walks and tick expiries.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    produce    = 1'b0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (in_action_i == ACT_ADD) ? S_WALK : S_TICK;
        end
      end
      S_WALK: begin
        if (st_i.full) begin
          if (out_free) begin
            cmd_o.reject = 1'b1;
            produce      = 1'b1;
            state_d      = S_IDLE;
          end
        end else if (st_i.walk_done) begin
          state_d = S_INSERT;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      S_INSERT: begin
        if (out_free) begin
          cmd_o.insert = 1'b1;
          produce      = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_TICK: begin
        if (st_i.empty) begin
          if (out_free) begin
            cmd_o.idle_result = 1'b1;
            produce           = 1'b1;
            state_d           = S_IDLE;
          end
        end else begin
          cmd_o.dec_head = 1'b1;
          state_d        = S_CHECK;
        end
      end
      S_CHECK: begin
        if (out_free) begin
          produce = 1'b1;
          if (st_i.can_fire) begin
            cmd_o.pop = 1'b1;
            if (st_i.fire_last) begin
              state_d = S_IDLE;
            end
          end else begin
            // Only reached before the first pop: the tick expired nothing.
            cmd_o.idle_result = 1'b1;
            state_d           = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result valid flag: set on a new result, cleared when the beat is taken.
  always_comb begin
    if (produce) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: sv/dltq_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module dltq_dp import dltq_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [DELTA_W-1:0] in_delay_i,
  input  wire logic [TAG_W-1:0]   in_tag_i,
  input  wire dltq_cmd_t          cmd_i,
  output dltq_status_t            st_o,
  output logic                    out_fired_o,
  output logic [TAG_W-1:0]        out_tag_o,
  output logic [CNT_W-1:0]        out_total_o,
  output logic                    out_rejected_o,
  output logic                    out_last_o
);

  // Slot storage; entries at or above the pending count hold stale data.
  logic [DELTA_W-1:0] slot_delta_q [DEPTH];
  logic [DELTA_W-1:0] slot_delta_d [DEPTH];
  logic [TAG_W-1:0]   slot_tag_q   [DEPTH];
  logic [TAG_W-1:0]   slot_tag_d   [DEPTH];

  logic [CNT_W-1:0]   pending_q, pending_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic [FIRE_W-1:0]  fire_cnt_q, fire_cnt_d;
  logic [DELTA_W-1:0] rem_q, rem_d;
  logic [TAG_W-1:0]   tag_q, tag_d;

  logic               res_fired_q, res_fired_d;
  logic [TAG_W-1:0]   res_tag_q, res_tag_d;
  logic [CNT_W-1:0]   res_total_q, res_total_d;
  logic               res_rej_q, res_rej_d;
  logic               res_last_q, res_last_d;

  logic [SLOT_W-1:0]  idx_sel;
  logic [DELTA_W-1:0] walk_delta;
  logic               at_end;
  logic               can_fire;
  logic               fire_last;

  // Walk read port: one slot per cycle at the walk index.
  assign idx_sel    = idx_q[SLOT_W-1:0];
  assign walk_delta = slot_delta_q[idx_sel];
  assign at_end     = (idx_q == pending_q);

  // Head expiry: a pop also decides whether another tag follows.
  assign can_fire  = (pending_q != '0) && (slot_delta_q[0] == '0) &&
                     (fire_cnt_q < FIRE_W'(MAX_FIRE));
  assign fire_last = (pending_q == CNT_W'(1)) || (slot_delta_q[1] != '0) ||
                     ((fire_cnt_q + FIRE_W'(1)) >= FIRE_W'(MAX_FIRE));

  assign st_o.full      = (pending_q == CNT_W'(DEPTH));
  assign st_o.empty     = (pending_q == '0);
  assign st_o.walk_done = at_end || (rem_q < walk_delta);
  assign st_o.can_fire  = can_fire;
  assign st_o.fire_last = fire_last;

  // Request and walk registers.
  always_comb begin
    idx_d      = idx_q;
    rem_d      = rem_q;
    tag_d      = tag_q;
    fire_cnt_d = fire_cnt_q;
    if (cmd_i.load) begin
      idx_d      = '0;
      rem_d      = in_delay_i;
      tag_d      = in_tag_i;
      fire_cnt_d = '0;
    end else if (cmd_i.walk_step) begin
      idx_d = idx_q + CNT_W'(1);
      rem_d = rem_q - walk_delta;
    end else if (cmd_i.pop) begin
      fire_cnt_d = fire_cnt_q + FIRE_W'(1);
    end
  end

  // Slot file update: insert with shift up, pop with shift down, head decrement.
  always_comb begin
    slot_delta_d = slot_delta_q;
    slot_tag_d   = slot_tag_q;
    pending_d    = pending_q;
    if (cmd_i.insert) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (CNT_W'(i) == idx_q) begin
          slot_delta_d[i] = rem_q;
          slot_tag_d[i]   = tag_q;
        end else if ((CNT_W'(i) == idx_q + CNT_W'(1)) && (idx_q < pending_q)) begin
          // The entry pushed past the new one keeps its absolute expiry.
          slot_delta_d[i] = slot_delta_q[(i == 0) ? 0 : i - 1] - rem_q;
          slot_tag_d[i]   = slot_tag_q[(i == 0) ? 0 : i - 1];
        end else if ((CNT_W'(i) > idx_q) && (CNT_W'(i) <= pending_q)) begin
          slot_delta_d[i] = slot_delta_q[(i == 0) ? 0 : i - 1];
          slot_tag_d[i]   = slot_tag_q[(i == 0) ? 0 : i - 1];
        end
      end
      pending_d = pending_q + CNT_W'(1);
    end else if (cmd_i.pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        slot_delta_d[i] = slot_delta_q[i + 1];
        slot_tag_d[i]   = slot_tag_q[i + 1];
      end
      pending_d = pending_q - CNT_W'(1);
    end else if (cmd_i.dec_head) begin
      if (slot_delta_q[0] != '0) begin
        slot_delta_d[0] = slot_delta_q[0] - DELTA_W'(1);
      end
    end
  end

  // Result register.
  always_comb begin
    res_fired_d = res_fired_q;
    res_tag_d   = res_tag_q;
    res_total_d = res_total_q;
    res_rej_d   = res_rej_q;
    res_last_d  = res_last_q;
    if (cmd_i.insert) begin
      res_fired_d = 1'b0;
      res_tag_d   = '0;
      res_total_d = pending_q + CNT_W'(1);
      res_rej_d   = 1'b0;
      res_last_d  = 1'b1;
    end else if (cmd_i.reject) begin
      res_fired_d = 1'b0;
      res_tag_d   = '0;
      res_total_d = pending_q;
      res_rej_d   = 1'b1;
      res_last_d  = 1'b1;
    end else if (cmd_i.idle_result) begin
      res_fired_d = 1'b0;
      res_tag_d   = '0;
      res_total_d = pending_q;
      res_rej_d   = 1'b0;
      res_last_d  = 1'b1;
    end else if (cmd_i.pop) begin
      res_fired_d = 1'b1;
      res_tag_d   = slot_tag_q[0];
      res_total_d = pending_q - CNT_W'(1);
      res_rej_d   = 1'b0;
      res_last_d  = fire_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q  <= '0;
      idx_q      <= '0;
      fire_cnt_q <= '0;
    end else begin
      pending_q  <= pending_d;
      idx_q      <= idx_d;
      fire_cnt_q <= fire_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_delta_q <= slot_delta_d;
    slot_tag_q   <= slot_tag_d;
    rem_q        <= rem_d;
    tag_q        <= tag_d;
    res_fired_q  <= res_fired_d;
    res_tag_q    <= res_tag_d;
    res_total_q  <= res_total_d;
    res_rej_q    <= res_rej_d;
    res_last_q   <= res_last_d;
  end

  assign out_fired_o    = res_fired_q;
  assign out_tag_o      = res_tag_q;
  assign out_total_o    = res_total_q;
  assign out_rejected_o = res_rej_q;
  assign out_last_o     = res_last_q;

endmodule

`default_nettype wire

// File: sv/delta_list_timer_queue_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Beat contents
// in_i     in   action, delay, event_tag: one tick or one timer add
// out_o    out  fired, expired_tag, entry_total, rejected, last: one result
//
// An add walks past at most the pending count of slots, reading one slot of
// the slot register file per cycle, and then inserts its entry; an add to a
// full list is rejected without a walk. A tick decrements the head delta and
// reports one result per expired tag, or a single result with no expiry when
// the list is empty or nothing expired.
// Reset clears the pending count and the handshake state; slot contents are
// only read below the pending count.
// A stalled result holds the sequencer; a new beat is taken while the last
// result of the previous beat still waits.
module delta_list_timer_queue_core import dltq_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dltq_in_if.sink    in_i,
  dltq_out_if.source out_o
);

  dltq_cmd_t    cmd;
  dltq_status_t st;

  dltq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  dltq_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_delay_i     (in_i.delay),
    .in_tag_i       (in_i.event_tag),
    .cmd_i          (cmd),
    .st_o           (st),
    .out_fired_o    (out_o.fired),
    .out_tag_o      (out_o.expired_tag),
    .out_total_o    (out_o.entry_total),
    .out_rejected_o (out_o.rejected),
    .out_last_o     (out_o.last)
  );

endmodule

`default_nettype wire

// File: sv/dltq_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module dltq_checker import dltq_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             out_valid_i,
  input wire logic             out_ready_i,
  input wire logic             out_fired_i,
  input wire logic [TAG_W-1:0] out_tag_i,
  input wire logic [CNT_W-1:0] out_total_i,
  input wire logic             out_rejected_i,
  input wire logic             out_last_i
);

  // A result beat stays offered until it is taken.
  `DLTQ_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result beat dropped")

  // The list never reports more entries than it has slots.
  `DLTQ_ASSERT_IMPLY(a_total_range, out_valid_i, out_total_i <= CNT_W'(DEPTH), "entry total too large")

  // A rejected add only comes from a full list and never fires.
  `DLTQ_ASSERT_IMPLY(a_reject_full, out_valid_i && out_rejected_i, (out_total_i == CNT_W'(DEPTH)) && !out_fired_i, "reject without full list")

  // Only expiry beats may be followed by further beats of the same item.
  `DLTQ_ASSERT_IMPLY(a_not_last_fires, out_valid_i && !out_last_i, out_fired_i, "non-final beat does not fire")

  // A beat that reports no expiry carries a zero tag.
  `DLTQ_ASSERT_IMPLY(a_idle_tag_zero, out_valid_i && !out_fired_i, out_tag_i == '0, "tag set without expiry")

endmodule

bind delta_list_timer_queue_core dltq_checker u_dltq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_fired_i    (out_o.fired),
  .out_tag_i      (out_o.expired_tag),
  .out_total_i    (out_o.entry_total),
  .out_rejected_i (out_o.rejected),
  .out_last_i     (out_o.last)
);

`default_nettype wire
